@@ rtl/tadc_pkg.sv @@
// Shared types and constants of the thermistor reading to temperature converter.
package tadc_pkg;

    // Fraction bits of the temperature result.
    localparam int TEMP_FRACTION_BITS = 8;

    localparam int CELLS     = 4;
    localparam int CELL_W    = 2;
    localparam int X_W       = 20;   // divider resistance width, widest log operand
    localparam int BETA_W    = 16;
    localparam int RAW_W     = 16;
    localparam int TEMP_W    = 18;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RDIV_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END       = 4'd8;

    localparam logic [X_W-1:0]    RDIV_RESET = 20'd10000;
    localparam logic [BETA_W-1:0] BETA_RESET = 16'd3380;

    // Base-2 logarithm unit: Q24 result, Q30 mantissa, one squaring per stage.
    localparam int LG_FRAC   = 24;
    localparam int LG_STEPS  = LG_FRAC;
    localparam int LG_LAT    = LG_STEPS + 1;
    localparam int LG_EW     = 5;
    localparam int LG_W      = LG_EW + LG_FRAC;
    localparam int LG_MANT_W = 31;

    localparam logic [X_W-1:0]   NOMINAL_R  = 20'd10000;
    localparam logic [RAW_W:0]   FULL_SCALE = 17'd32768;

    // 29815 * ln2 in Q16, and T0 in centikelvin times 100.
    localparam logic [30:0] T0_LN2  = 31'd1354376190;
    localparam logic [21:0] N_SCALE = 22'd2981500;
    localparam int MAG_W  = 30;
    localparam int TERM_W = 45;
    localparam int D_W    = 49;
    localparam int DD_W   = 47;
    localparam int N_W    = 38;

    // Quotient bits of the long division; at or above 2^Q_W the result saturates.
    localparam int Q_W      = 50;
    localparam int N_PRE    = Q_W - (LG_FRAC + TEMP_FRACTION_BITS + 1);

    localparam longint ZERO_C = 27315 * (64'sd1 <<< TEMP_FRACTION_BITS);
    localparam int     C_W    = 29;
    localparam longint C_LIM  = 64'sd1 <<< (C_W - 1);

    // Unit conversion: floor(y/100) = floor((y/4)/25), floor(y/500) = floor((y/4)/125),
    // each by a reciprocal multiply that is exact over the operand range.
    localparam longint C_OFS  = 50 + 100 * (64'sd1 <<< 22);
    localparam longint F_OFS  = 16000 * (64'sd1 <<< TEMP_FRACTION_BITS) + 250
                                + 500 * (64'sd1 <<< 23);
    localparam int     Y_W    = 36;
    localparam int     Y4_W   = 31;
    localparam logic [31:0] RECIP_C = 32'd343597384;
    localparam logic [31:0] RECIP_F = 32'd2199023256;
    localparam int     SH_C   = 33;
    localparam int     SH_F   = 38;
    localparam int     PROD_W = 63;
    localparam int     QUOT_W = 30;
    localparam logic signed [31:0] T_OFS_C = 32'sd4194304;
    localparam logic signed [31:0] T_OFS_F = 32'sd8388608;
    localparam logic signed [31:0] T_MAX   = 32'sd131071;
    localparam logic signed [31:0] T_MIN   = -32'sd131072;

    // Cycles from the accepting edge to the edge at which the result transfers.
    localparam int PIPE_LAT = LG_LAT + Q_W + 9;

    typedef struct packed {
        logic               kind;
        logic [CELL_W-1:0]  cell_req;
        logic [RAW_W-1:0]   raw_reading;
    } t_item;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     valid_res;
    } t_result;

    typedef struct packed {
        logic              vld;
        logic              kind;
        logic              bad;
        logic              sat;
        logic [BETA_W-1:0] beta;
    } t_side;

endpackage

@@ rtl/tadc_log2.sv @@
// Pipelined base-2 logarithm in Q24, one fraction bit per stage.
module tadc_log2 (
    input  logic                       i_clk,
    input  logic [tadc_pkg::X_W-1:0]   i_x,
    output logic [tadc_pkg::LG_W-1:0]  o_lg
);
    import tadc_pkg::*;

    logic [LG_EW-1:0]     r_e [0:LG_STEPS];
    logic [LG_MANT_W-1:0] r_m [0:LG_STEPS];
    logic [LG_FRAC-1:0]   r_f [0:LG_STEPS];

    logic [LG_EW-1:0]     n_e;
    logic [LG_MANT_W-1:0] n_m;

    // The integer part is the position of the leading one.
    always_comb begin
        n_e = '0;
        for (int i = 1; i < X_W; i++) begin
            if (i_x[i]) begin
                n_e = LG_EW'(i);
            end
        end
        n_m = LG_MANT_W'(i_x) << (LG_EW'(LG_MANT_W - 1) - n_e);
    end

    always_ff @(posedge i_clk) begin
        r_e[0] <= n_e;
        r_m[0] <= n_m;
        r_f[0] <= '0;
    end

    for (genvar k = 1; k <= LG_STEPS; k++) begin : g_step
        logic [2*LG_MANT_W-1:0] n_sq;
        logic [LG_MANT_W:0]     n_sh;
        logic [LG_FRAC-1:0]     n_f;

        always_comb begin
            n_sq = (2*LG_MANT_W)'(r_m[k-1]) * (2*LG_MANT_W)'(r_m[k-1]);
            n_sh = n_sq[2*LG_MANT_W-1:LG_MANT_W-1];
            n_f  = r_f[k-1];
            n_f[LG_FRAC-k] = n_sh[LG_MANT_W];
        end

        always_ff @(posedge i_clk) begin
            r_e[k] <= r_e[k-1];
            r_f[k] <= n_f;
            if (n_sh[LG_MANT_W]) begin
                r_m[k] <= n_sh[LG_MANT_W:1];
            end else begin
                r_m[k] <= n_sh[LG_MANT_W-1:0];
            end
        end
    end

    assign o_lg = {r_e[LG_STEPS], r_f[LG_STEPS]};

endmodule

@@ rtl/thermistor_adc_to_temperature.sv @@
// Top level of the thermistor reading to temperature converter (beta equation).
//
// The converter takes one reading in every clock cycle and never stalls: busy stays low,
// and each transfer on start comes back as one result, in order. The receiver cannot
// hold results off, so a result is on o_res for one cycle only. Most stages are the
// pipelined base-2 logarithms (25 stages: normalise, then one fraction bit each) and
// the restoring divider that forms the temperature (50 stages, one quotient bit each);
// the other stages form the denominator, test for saturation and do the unit conversion
// with a reciprocal multiply. Each cell's divider resistance and beta come from the
// configuration channel, which is always ready; registers are to be written only while
// no reading is in flight. A reading of zero or of 32768 and above, or a cell with a
// zero resistance or beta, gives a result with valid_res low and temperature zero.
module thermistor_adc_to_temperature (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  tadc_pkg::t_item                     i_item,
    output logic                                o_res_strobe,
    output tadc_pkg::t_result                   o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tadc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tadc_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import tadc_pkg::*;

    // Configuration registers.
    logic [X_W-1:0]    r_rdiv [0:CELLS-1];
    logic [BETA_W-1:0] r_beta [0:CELLS-1];

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                r_rdiv[i] <= RDIV_RESET;
                r_beta[i] <= BETA_RESET;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index < CFG_BETA_BASE) begin
                r_rdiv[i_cfg_index[CELL_W-1:0]] <= i_cfg_data[X_W-1:0];
            end else if (i_cfg_index < CFG_END) begin
                r_beta[i_cfg_index[CELL_W-1:0]] <= i_cfg_data[BETA_W-1:0];
            end
        end
    end

    // Entry stage: look up the cell and screen out readings with no finite, nonzero resistance or a zero beta.
    logic              n_acc;
    logic [X_W-1:0]    n_rdiv;
    logic [BETA_W-1:0] n_b;
    logic              n_bad;
    t_side             r_s0;
    logic [X_W-1:0]    r_x0, r_x1, r_x2;

    always_comb begin
        n_acc  = start && !busy;
        n_rdiv = r_rdiv[i_item.cell_req];
        n_b    = r_beta[i_item.cell_req];
        n_bad  = (i_item.raw_reading == '0) || i_item.raw_reading[RAW_W-1]
                 || (n_rdiv == '0) || (n_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0 <= '0;
        end else begin
            r_s0.vld  <= n_acc;
            r_s0.kind <= i_item.kind;
            r_s0.bad  <= n_bad;
            r_s0.sat  <= 1'b0;
            r_s0.beta <= n_b;
        end
    end

    // Bad readings feed ones into the logarithms; their results are discarded anyway.
    always_ff @(posedge i_clk) begin
        r_x0 <= n_bad ? X_W'(1) : n_rdiv;
        r_x1 <= n_bad ? X_W'(1) : X_W'(i_item.raw_reading);
        r_x2 <= n_bad ? X_W'(1) : X_W'(FULL_SCALE - (RAW_W+1)'(i_item.raw_reading));
    end

    // Four logarithm lanes; the nominal resistance lane folds to a constant.
    logic [LG_W-1:0] w_lg_rdiv, w_lg_v, w_lg_rest, w_lg_nom;

    tadc_log2 u_lg_rdiv (.i_clk(i_clk), .i_x(r_x0),      .o_lg(w_lg_rdiv));
    tadc_log2 u_lg_v    (.i_clk(i_clk), .i_x(r_x1),      .o_lg(w_lg_v));
    tadc_log2 u_lg_rest (.i_clk(i_clk), .i_x(r_x2),      .o_lg(w_lg_rest));
    tadc_log2 u_lg_nom  (.i_clk(i_clk), .i_x(NOMINAL_R), .o_lg(w_lg_nom));

    // Side information travels alongside the logarithm stages.
    t_side r_sd [0:LG_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LG_LAT; i++) begin
                r_sd[i] <= '0;
            end
        end else begin
            r_sd[0] <= r_s0;
            for (int i = 1; i < LG_LAT; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // Stage A: log of R/R0 as a signed sum, split into sign and magnitude.
    logic signed [31:0] n_lsum;
    t_side              r_sa;
    logic               r_neg;
    logic [MAG_W-1:0]   r_mag;

    assign n_lsum = $signed({3'b0, w_lg_rdiv}) + $signed({3'b0, w_lg_v})
                  - $signed({3'b0, w_lg_rest}) - $signed({3'b0, w_lg_nom});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= '0;
        end else begin
            r_sa <= r_sd[LG_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_lsum[31];
        r_mag <= n_lsum[31] ? MAG_W'(-n_lsum) : MAG_W'(n_lsum);
    end

    // Stage B: scale the log by T0 * ln2, rounded.
    t_side             r_sb;
    logic              r_neg_b;
    logic [TERM_W-1:0] r_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb <= '0;
        end else begin
            r_sb <= r_sa;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg_b <= r_neg;
        r_term  <= TERM_W'((61'(r_mag) * 61'(T0_LN2) + 61'd32768) >> 16);
    end

    // Stage C: denominator 100*B + T0*ln(R/R0) in Q24, and numerator 100*T0*B.
    logic [22:0]           n_b100;
    logic signed [D_W-1:0] n_dpos_part;
    t_side                 r_sc;
    logic signed [D_W-1:0] r_d;
    logic [N_W-1:0]        r_n;

    always_comb begin
        n_b100      = 23'(32'(r_sb.beta) * 32'd100);
        n_dpos_part = $signed({2'b0, n_b100, 24'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= '0;
        end else begin
            r_sc <= r_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= r_neg_b ? n_dpos_part - $signed({4'b0, r_term})
                       : n_dpos_part + $signed({4'b0, r_term});
        r_n <= N_W'(64'(r_sb.beta) * 64'(N_SCALE));
    end

    // Stage D: saturation test and divider setup. A non-positive denominator, or a
    // quotient that would reach 2^Q_W, means far too hot.
    logic              n_dpos;
    logic [DD_W-1:0]   n_dd;
    logic              n_sat;
    t_side             n_sc;

    always_comb begin
        n_dpos = !r_d[D_W-1] && (r_d != '0);
        n_dd   = r_d[DD_W-1:0];
        n_sat  = !n_dpos || ({26'b0, r_n} >= {n_dd, N_PRE'(0)});
        n_sc     = r_sc;
        n_sc.sat = n_sat;
    end

    t_side            r_dside [0:Q_W];
    logic [DD_W-1:0]  r_dr    [0:Q_W];
    logic [DD_W-1:0]  r_ddv   [0:Q_W];
    logic [Q_W-1:0]   r_dn    [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dside[0] <= '0;
        end else begin
            r_dside[0] <= n_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dr[0]  <= DD_W'(r_n[N_W-1:N_PRE]);
        r_ddv[0] <= n_dd;
        r_dn[0]  <= {r_n[N_PRE-1:0], (Q_W-N_PRE)'(0)};
    end

    // Restoring division, one quotient bit per stage. The dividend bits leave the top
    // of r_dn while the quotient bits enter at the bottom.
    for (genvar j = 1; j <= Q_W; j++) begin : g_div
        logic [DD_W:0] n_r2;
        logic          n_ge;

        always_comb begin
            n_r2 = {r_dr[j-1], r_dn[j-1][Q_W-1]};
            n_ge = n_r2 >= {1'b0, r_ddv[j-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dside[j] <= '0;
            end else begin
                r_dside[j] <= r_dside[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dr[j]  <= n_ge ? DD_W'(n_r2 - {1'b0, r_ddv[j-1]}) : DD_W'(n_r2);
            r_ddv[j] <= r_ddv[j-1];
            r_dn[j]  <= {r_dn[j-1][Q_W-2:0], n_ge};
        end
    end

    // Stage E: round to centikelvin with 8 fraction bits, move to Celsius, clamp to a range
    // that still saturates the result in either unit.
    logic [Q_W-1:0]        n_q;
    logic signed [51:0]    n_c;
    t_side                 r_se;
    logic signed [C_W-1:0] r_c;

    always_comb begin
        n_q = Q_W'(((Q_W+1)'(r_dn[Q_W]) + (Q_W+1)'(1)) >> 1);
        n_c = $signed({2'b0, n_q}) - 52'(ZERO_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_se <= '0;
        end else begin
            r_se <= r_dside[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_c > 52'(C_LIM - 1)) begin
            r_c <= C_W'(C_LIM - 1);
        end else if (n_c < 52'(-C_LIM)) begin
            r_c <= C_W'(-C_LIM);
        end else begin
            r_c <= C_W'(n_c);
        end
    end

    // Stage F: offset into a non-negative dividend and take out the common factor 4.
    logic signed [Y_W-1:0] n_y;
    t_side                 r_sf;
    logic [Y4_W-1:0]       r_y4;

    always_comb begin
        if (r_se.kind) begin
            n_y = Y_W'(r_c) * Y_W'(9) + Y_W'(F_OFS);
        end else begin
            n_y = Y_W'(r_c) + Y_W'(C_OFS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf <= '0;
        end else begin
            r_sf <= r_se;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y4 <= n_y[Y4_W+1:2];
    end

    // Stage G: reciprocal multiply.
    t_side             r_sg;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sg <= '0;
        end else begin
            r_sg <= r_sf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_y4) * PROD_W'(r_sf.kind ? RECIP_F : RECIP_C);
    end

    // Stage H: remove the offset, saturate and select the special cases.
    logic [QUOT_W-1:0]  n_quot;
    logic signed [31:0] n_t;
    logic signed [31:0] n_tsat;

    always_comb begin
        n_quot = r_sg.kind ? QUOT_W'(r_prod >> SH_F) : QUOT_W'(r_prod >> SH_C);
        n_t    = $signed({2'b0, n_quot}) - (r_sg.kind ? T_OFS_F : T_OFS_C);
        if (n_t > T_MAX) begin
            n_tsat = T_MAX;
        end else if (n_t < T_MIN) begin
            n_tsat = T_MIN;
        end else begin
            n_tsat = n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res_strobe <= 1'b0;
        end else begin
            o_res_strobe <= r_sg.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sg.bad) begin
            o_res.temperature <= '0;
            o_res.valid_res   <= 1'b0;
        end else if (r_sg.sat) begin
            o_res.temperature <= TEMP_W'(T_MAX);
            o_res.valid_res   <= 1'b1;
        end else begin
            o_res.temperature <= TEMP_W'(n_tsat);
            o_res.valid_res   <= 1'b1;
        end
    end

endmodule

@@ rtl/tadc_checker.sv @@
// Port-level checker for the thermistor converter, bound to the top level.
module tadc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input tadc_pkg::t_item    i_item,
    input logic               o_res_strobe,
    input tadc_pkg::t_result  o_res
);
    import tadc_pkg::*;

    // Every result comes from a transfer exactly the pipeline latency earlier.
    a_strobe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(start && !busy, PIPE_LAT))
        else $error("result strobe without a matching transfer");

    // A reading with no finite resistance never yields a valid temperature.
    a_bad_reading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && $past(start && !busy && ((i_item.raw_reading == '0)
            || i_item.raw_reading[RAW_W-1]), PIPE_LAT) |-> !o_res.valid_res)
        else $error("out of range reading reported as valid");

    // Invalid results carry a zero temperature.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe && !o_res.valid_res |-> o_res.temperature == '0)
        else $error("invalid result with nonzero temperature");

endmodule

bind thermistor_adc_to_temperature tadc_checker u_tadc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_item      (i_item),
    .o_res_strobe(o_res_strobe),
    .o_res       (o_res)
);
